[hw/rtl/sfr_pkg.sv]
// Shared definitions for the serial frame receiver: header codes, result
// status codes, sequencer states and default sizes. No dependencies.
`default_nettype none

package sfr_pkg;

    // Default frame store size in bytes (one extra entry is kept for overrun)
    localparam int BUFFER_BYTES_DEF = 32;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;
    localparam int LEN_W    = 9;   // header length byte plus a small offset
    localparam int TDATA_W  = 24;  // status, frame byte, index, padded to bytes

    // Header byte codes
    localparam logic [BYTE_W-1:0] HDR_EE = 8'hEE;
    localparam logic [BYTE_W-1:0] HDR_DD = 8'hDD;
    localparam logic [BYTE_W-1:0] HDR_AA = 8'hAA;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_PROGRESS = 3'd0;
    localparam logic [STATUS_W-1:0] STS_REJECT   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] STS_CSUM_ERR = 3'd3;
    localparam logic [STATUS_W-1:0] STS_ACCEPTED = 3'd4;

    // Frame kind codes
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_CTRL = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OUT,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // Outcome of one received byte
    typedef enum logic [2:0] {
        OC_PROGRESS,
        OC_REJECT,
        OC_OVERFLOW,
        OC_CHECK,
        OC_EMIT
    } outcome_t;

endpackage

`default_nettype wire

[hw/rtl/serial_frame_receiver_top.sv]
// Serial frame receiver top level: frame store, byte counter, checksum walk
// and frame emission sequencer. Depends on sfr_pkg.
//
// The block takes one received byte per s_ transaction and stores it in a
// BUFFER_BYTES+1 entry frame store. A byte that does not complete a frame
// yields one result in the cycle right after it is accepted (accept, then
// present). A completed data frame first runs a checksum walk over the
// store's single read port (read, then accumulate, per byte) for bytes 0
// through length byte plus two; if the checksum matches, it then emits every
// stored byte (read, load, present), else one checksum error result.
// A control frame skips the walk. s_tready is high only while the sequencer
// is idle. The store needs no clearing after reset: every entry read has been
// written since the last restart.
`default_nettype none

module serial_frame_receiver_top
    import sfr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [2:0] status, [10:3] frame_byte,
                                               // [16:11] byte_index, rest zero
    output logic                    m_tuser,   // [0] frame_kind
    output logic                    m_tlast    // last
);

    localparam int DEPTH  = BUFFER_BYTES + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;

    // Frame store
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Control and datapath registers
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   byte_count_reg, byte_count_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [ADDR_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]    fcnt_reg, fcnt_next;
    logic [BYTE_W-1:0]   acc_reg, acc_next;
    logic [BYTE_W-1:0]   h0_reg, h0_next;
    logic [BYTE_W-1:0]   h1_reg, h1_next;
    logic [BYTE_W-1:0]   b3_reg, b3_next;
    logic [BYTE_W-1:0]   b5_reg, b5_next;
    logic                kind_reg, kind_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    logic                out_last_reg, out_last_next;

    // Byte decode
    logic                s_xact;
    logic [ADDR_W-1:0]   wr_addr;
    logic [CNT_W-1:0]    cnt;
    logic [BYTE_W-1:0]   len_byte;
    logic [LEN_W-1:0]    data_len;
    logic [LEN_W-1:0]    ctrl_len;
    logic [LEN_W-1:0]    cnt_ext;
    logic                hdr_data;
    logic                hdr_ctrl;
    outcome_t            outcome;
    logic                emit_last;

    assign s_xact   = s_tvalid && s_tready;
    assign wr_addr  = (byte_count_reg > ADDR_W'(BUFFER_BYTES)) ? '0 : byte_count_reg;
    assign cnt      = CNT_W'(wr_addr) + CNT_W'(1);
    assign cnt_ext  = LEN_W'(cnt);
    // Length byte of a data frame may be the byte arriving now
    assign len_byte = (cnt == CNT_W'(6)) ? s_tdata : b5_reg;
    assign data_len = LEN_W'(len_byte) + LEN_W'(2);
    assign ctrl_len = LEN_W'(b3_reg) + LEN_W'(1);
    assign hdr_data = (h0_reg == HDR_EE) && ((h1_reg == HDR_EE) || (h1_reg == HDR_AA));
    assign hdr_ctrl = (h0_reg == HDR_DD) && (h1_reg == HDR_DD);
    assign emit_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == fcnt_reg);

    // Classify the received byte
    always_comb begin
        priority if (cnt == CNT_W'(1)) begin
            outcome = ((s_tdata != HDR_EE) && (s_tdata != HDR_DD)) ? OC_REJECT : OC_PROGRESS;
        end else if (cnt == CNT_W'(2)) begin
            outcome = ((s_tdata != HDR_EE) && (s_tdata != HDR_AA) && (s_tdata != HDR_DD))
                      ? OC_REJECT : OC_PROGRESS;
        end else if (cnt < CNT_W'(6)) begin
            outcome = OC_PROGRESS;
        end else if (cnt > CNT_W'(BUFFER_BYTES)) begin
            outcome = OC_OVERFLOW;
        end else if (hdr_data) begin
            outcome = (cnt_ext > data_len) ? OC_CHECK : OC_PROGRESS;
        end else if (hdr_ctrl) begin
            outcome = (cnt_ext > ctrl_len) ? OC_EMIT : OC_PROGRESS;
        end else begin
            outcome = OC_REJECT;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xact) begin
                    unique case (outcome)
                        OC_CHECK: state_next = ST_SUM_RD;
                        OC_EMIT:  state_next = ST_EMIT_RD;
                        default:  state_next = ST_OUT;
                    endcase
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = out_last_reg ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_SUM_RD:  state_next = ST_SUM_ACC;
            ST_SUM_ACC: begin
                if (ptr_reg == len_reg) begin
                    state_next = (acc_reg == rd_data_reg) ? ST_EMIT_RD : ST_OUT;
                end else begin
                    state_next = ST_SUM_RD;
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD: state_next = ST_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and port outputs
    always_comb begin
        byte_count_next = byte_count_reg;
        ptr_next        = ptr_reg;
        len_next        = len_reg;
        fcnt_next       = fcnt_reg;
        acc_next        = acc_reg;
        h0_next         = h0_reg;
        h1_next         = h1_reg;
        b3_next         = b3_reg;
        b5_next         = b5_reg;
        kind_next       = kind_reg;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;

        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xact) begin
                    // Capture header bytes as they pass
                    if (cnt == CNT_W'(1)) h0_next = s_tdata;
                    if (cnt == CNT_W'(2)) h1_next = s_tdata;
                    if (cnt == CNT_W'(4)) b3_next = s_tdata;
                    if (cnt == CNT_W'(6)) b5_next = s_tdata;

                    byte_count_next = ADDR_W'(cnt);
                    fcnt_next       = cnt;
                    ptr_next        = '0;
                    acc_next        = '0;
                    len_next        = ADDR_W'(data_len);
                    out_byte_next   = '0;
                    out_index_next  = '0;
                    out_last_next   = 1'b1;
                    kind_next       = KIND_DATA;
                    unique case (outcome)
                        OC_PROGRESS: out_status_next = STS_PROGRESS;
                        OC_REJECT: begin
                            out_status_next = STS_REJECT;
                            byte_count_next = '0;
                        end
                        OC_OVERFLOW: begin
                            out_status_next = STS_OVERFLOW;
                            byte_count_next = '0;
                        end
                        OC_CHECK: byte_count_next = '0;
                        OC_EMIT: begin
                            kind_next       = KIND_CTRL;
                            byte_count_next = '0;
                        end
                        default: out_status_next = STS_PROGRESS;
                    endcase
                end
            end
            ST_OUT: begin
                // Advance to the next stored byte once this one is taken
                if (m_tready && !out_last_reg) begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            ST_SUM_RD: begin
            end
            ST_SUM_ACC: begin
                if (ptr_reg == len_reg) begin
                    ptr_next = '0;
                    if (acc_reg != rd_data_reg) begin
                        out_status_next = STS_CSUM_ERR;
                        out_byte_next   = '0;
                        out_index_next  = '0;
                        out_last_next   = 1'b1;
                        kind_next       = KIND_DATA;
                    end
                end else begin
                    acc_next = acc_reg ^ rd_data_reg;
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            ST_EMIT_RD: begin
            end
            ST_EMIT_LD: begin
                out_status_next = STS_ACCEPTED;
                out_byte_next   = rd_data_reg;
                out_index_next  = INDEX_W'(ptr_reg);
                out_last_next   = emit_last;
            end
            default: begin
            end
        endcase
    end

    // Result port: kind reads zero except on accepted frame bytes
    assign m_tdata = {TDATA_W'(0)} | TDATA_W'({out_index_reg, out_byte_reg, out_status_reg});
    assign m_tuser = (out_status_reg == STS_ACCEPTED) ? kind_reg : 1'b0;
    assign m_tlast = out_last_reg;

    // Frame store write and registered read
    always_ff @(posedge aclk) begin
        if (s_xact) begin
            mem[wr_addr] <= s_tdata;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            byte_count_reg <= '0;
        end else begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ptr_reg        <= ptr_next;
        len_reg        <= len_next;
        fcnt_reg       <= fcnt_next;
        acc_reg        <= acc_next;
        h0_reg         <= h0_next;
        h1_reg         <= h1_next;
        b3_reg         <= b3_next;
        b5_reg         <= b5_next;
        kind_reg       <= kind_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
        out_index_reg  <= out_index_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire

[hw/rtl/sfr_checker.sv]
// Port-level checker for the serial frame receiver, bound to the top level.
// Depends on sfr_pkg and serial_frame_receiver_top.
`default_nettype none

module sfr_checker
    import sfr_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic               m_tuser,
    input wire logic               m_tlast
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Never take a byte while a result is pending
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // Drop ready right after a byte is taken
    a_busy_after_xact: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after input transaction");

    // Status codes stay in range
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= STS_ACCEPTED))
        else $error("status code out of range");

    // Non-accepted outcomes are a single zeroed transaction
    a_single_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != STS_ACCEPTED) |->
            m_tlast && !m_tuser && (m_tdata[TDATA_W-1:3] == '0))
        else $error("non-accepted result malformed");

endmodule

bind serial_frame_receiver_top sfr_checker u_sfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
